@@ hdl/nlrp_pkg.sv @@
package nlrp_pkg;

   // One character of a number token
   typedef struct packed {
      logic [7:0] char_code;
      logic       is_final;
   } req_type;

   // Converted token
   typedef struct packed {
      logic [31:0] number_value;
      logic        bad_literal;
   } rsp_type;

   // Kind of prefix seen at the start of the token
   typedef enum logic [1:0] {
      KIND_DEC,
      KIND_ZERO,
      KIND_DOLLAR,
      KIND_ZEROX
   } prefix_kind_type;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_H      = 8'h68;
   localparam logic [7:0] CHAR_O      = 8'h6F;
   localparam logic [7:0] CHAR_Q      = 8'h71;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   // Digit weight limits used for the per-radix bad digit flags, and the weight of 'a'
   localparam logic [3:0] LIMIT_BIN = 4'd2;
   localparam logic [3:0] LIMIT_OCT = 4'd8;
   localparam logic [3:0] LIMIT_DEC = 4'd10;
   localparam logic [3:0] HEX_BASE  = 4'd10;

   // Index of each radix in the bad digit flags
   localparam int FLAG_BIN = 0;
   localparam int FLAG_OCT = 1;
   localparam int FLAG_DEC = 2;
   localparam int FLAG_HEX = 3;

endpackage

@@ hdl/numeric_literal_radix_parser_top.sv @@
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_data  (char_code, is_final)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data  (number_value, bad_literal)
//
// One character per cycle while req_ready is high: each accepted character is held
// and the one held before it is shifted into the four running values (radix 2, 8,
// 10 and 16); the final character also loads the result register, so its result
// appears in the cycle after its transfer. The decimal path, with two chained
// multiply-by-ten adds on a final character, sets the cycle time.
// Reset (synchronous, active high) clears all token state and the result valid flag.
// A character is taken while the result register is empty or being drained.
module numeric_literal_radix_parser_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nlrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nlrp_pkg::rsp_type rsp_data
);
   import nlrp_pkg::*;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      value_type bin;
      value_type oct;
      value_type dec;
      value_type hex;
   } acc_set_type;

   typedef struct packed {
      logic [3:0] weight;
      logic [3:0] flags;
   } digit_type;

   // Decode a folded character into its digit weight and bad-radix flags
   function automatic digit_type decode_digit(logic [7:0] c);
      digit_type r;
      r.weight = 4'd0;
      r.flags  = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.weight = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_A && c <= CHAR_F) begin
         r.weight = 4'(c - CHAR_A) + HEX_BASE;
      end else begin
         r.flags = 4'hF;
      end
      if (r.weight >= LIMIT_BIN) r.flags[FLAG_BIN] = 1'b1;
      if (r.weight >= LIMIT_OCT) r.flags[FLAG_OCT] = 1'b1;
      if (r.weight >= LIMIT_DEC) r.flags[FLAG_DEC] = 1'b1;
      return r;
   endfunction

   // Shift one digit into all four running values
   function automatic acc_set_type acc_step(acc_set_type a, logic [3:0] d);
      acc_set_type r;
      value_type   dz;
      dz    = value_type'(d);
      r.bin = (a.bin << 1) + dz;
      r.oct = (a.oct << 3) + dz;
      r.dec = (a.dec << 3) + (a.dec << 1) + dz;
      r.hex = (a.hex << 4) + dz;
      return r;
   endfunction

   // Token state
   acc_set_type     acc_ff,  acc_in;
   logic [7:0]      held_ff, held_in;
   logic [3:0]      bad_ff,  bad_in;
   logic [1:0]      seen_ff, seen_in;
   prefix_kind_type kind_ff, kind_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   logic        accept;
   logic        fin;
   logic [7:0]  c;
   digit_type   held_dig, c_dig;
   logic        held_take, c_skip, suffix;
   acc_set_type stage1, stage2;
   logic [3:0]  bad1, bad2;
   value_type   value;
   logic        invalid;
   logic [VALUE_BITS+31:0] value_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      fin = req_data.is_final;
      // fold upper case to lower case
      c = req_data.char_code;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         c = c | CASE_BIT;
      end

      // held character: skip '$' in first place and the 'x' of a "0x" prefix
      held_dig  = decode_digit(held_ff);
      held_take = (seen_ff != 2'd0) &&
                  !((seen_ff == 2'd1 && held_ff == CHAR_DOLLAR) ||
                    (seen_ff == 2'd2 && kind_ff == KIND_ZEROX));
      stage1 = held_take ? acc_step(acc_ff, held_dig.weight) : acc_ff;
      bad1   = held_take ? (bad_ff | held_dig.flags) : bad_ff;

      // track position and prefix kind
      kind_in = kind_ff;
      if (seen_ff == 2'd0) begin
         if (c == CHAR_ZERO) begin
            kind_in = KIND_ZERO;
         end else if (c == CHAR_DOLLAR) begin
            kind_in = KIND_DOLLAR;
         end else begin
            kind_in = KIND_DEC;
         end
      end else if (seen_ff == 2'd1 && kind_ff == KIND_ZERO && c == CHAR_X) begin
         kind_in = KIND_ZEROX;
      end
      seen_in = (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
      held_in = c;

      // final character taken as a digit unless it is a prefix character or a radix suffix
      c_dig  = decode_digit(c);
      c_skip = (seen_ff == 2'd0 && c == CHAR_DOLLAR) ||
               (seen_ff == 2'd1 && kind_in == KIND_ZEROX);
      stage2 = c_skip ? stage1 : acc_step(stage1, c_dig.weight);
      bad2   = c_skip ? bad1 : (bad1 | c_dig.flags);
      suffix = (c == CHAR_H) || (c == CHAR_O) || (c == CHAR_Q) || (c == CHAR_B);

      priority if (c == CHAR_H) begin
         value   = stage1.hex;
         invalid = bad1[FLAG_HEX] || kind_in == KIND_DOLLAR || kind_in == KIND_ZEROX;
      end else if (c == CHAR_B) begin
         value   = stage1.bin;
         invalid = bad1[FLAG_BIN] || kind_in == KIND_DOLLAR || kind_in == KIND_ZEROX;
      end else if (suffix) begin
         value   = stage1.oct;
         invalid = bad1[FLAG_OCT] || kind_in == KIND_DOLLAR || kind_in == KIND_ZEROX;
      end else begin
         unique case (kind_in)
            KIND_ZERO: begin
               value   = stage2.oct;
               invalid = bad2[FLAG_OCT];
            end
            KIND_DEC: begin
               value   = stage2.dec;
               invalid = bad2[FLAG_DEC];
            end
            KIND_DOLLAR, KIND_ZEROX: begin
               value   = stage2.hex;
               invalid = bad2[FLAG_HEX];
            end
            default: begin
               value   = stage2.dec;
               invalid = bad2[FLAG_DEC];
            end
         endcase
      end

      // drop the value on an invalid token; widen or trim to 32 bits
      value_ext                = {32'd0, value};
      rsp_data_in.number_value = invalid ? 32'd0 : value_ext[31:0];
      rsp_data_in.bad_literal  = invalid;

      acc_in = stage1;
      bad_in = bad1;

      rsp_valid_in = rsp_valid_ff;
      if (accept && fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         bad_ff       <= '0;
         seen_ff      <= '0;
         kind_ff      <= KIND_DEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (fin) begin
               // token done: return to the empty state
               acc_ff  <= '0;
               held_ff <= '0;
               bad_ff  <= '0;
               seen_ff <= '0;
               kind_ff <= KIND_DEC;
            end else begin
               acc_ff  <= acc_in;
               held_ff <= held_in;
               bad_ff  <= bad_in;
               seen_ff <= seen_in;
               kind_ff <= kind_in;
            end
         end
      end
   end

   // hold the result until its transfer
   always_ff @(posedge clock) begin
      if (accept && fin) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
